// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define TCM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked also through reset.
`define TCM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/tcm_pkg.sv -----
// Shared constants and register codes for the tiled coordinate mapper.
package tcm_pkg;

    localparam int FIELD_W          = 64;
    localparam int LOCAL_W          = 12;
    localparam int INDEX_W          = 20;
    localparam int CHUNK_REG_W      = 13;
    localparam int LARGE_REG_W      = 20;
    localparam int CFG_INDEX_W      = 8;
    localparam int CFG_DATA_W       = 32;
    localparam int COORD_WIDTH_DEF  = 64;
    localparam int MAX_CHUNK_DEF    = 4096;
    localparam int MAX_LARGE_DEF    = 1000000;
    localparam int CHUNK_AREA_LIMIT = 1048576;
    localparam int AREA_CMP_W       = 27;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHUNK_WIDTH  = 8'd0,
        CFG_CHUNK_HEIGHT = 8'd1,
        CFG_LARGE_WIDTH  = 8'd2,
        CFG_LARGE_HEIGHT = 8'd3
    } cfg_index_t;

endpackage

// ----- rtl/tcm_div_cell.sv -----
// One restoring-division cell: one quotient bit per lane, x and y lanes side by side.
module tcm_div_cell #(
    parameter int NW  = 64,
    parameter int DW  = 13,
    parameter int SBW = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_i,
    input  logic [DW-1:0]  dx,
    input  logic [DW-1:0]  dy,
    input  logic [DW-1:0]  rx_i,
    input  logic [DW-1:0]  ry_i,
    input  logic [NW-1:0]  wx_i,
    input  logic [NW-1:0]  wy_i,
    input  logic [SBW-1:0] sb_i,
    output logic           vld_o,
    output logic [DW-1:0]  rx_o,
    output logic [DW-1:0]  ry_o,
    output logic [NW-1:0]  wx_o,
    output logic [NW-1:0]  wy_o,
    output logic [SBW-1:0] sb_o
);

    logic [DW:0]   tx, ty, sx, sy;
    logic          gex, gey;
    logic          vld_reg;
    logic [DW-1:0] rx_reg, ry_reg, rx_next, ry_next;
    logic [NW-1:0] wx_reg, wy_reg;
    logic [SBW-1:0] sb_reg;

    // shift the next dividend bit into the partial remainder, subtract if it fits
    assign tx  = {rx_i, wx_i[NW-1]};
    assign ty  = {ry_i, wy_i[NW-1]};
    assign sx  = tx - {1'b0, dx};
    assign sy  = ty - {1'b0, dy};
    assign gex = (tx >= {1'b0, dx});
    assign gey = (ty >= {1'b0, dy});
    assign rx_next = gex ? sx[DW-1:0] : tx[DW-1:0];
    assign ry_next = gey ? sy[DW-1:0] : ty[DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            wx_reg <= {wx_i[NW-2:0], gex};
            wy_reg <= {wy_i[NW-2:0], gey};
            sb_reg <= sb_i;
        end
    end

    assign vld_o = vld_reg;
    assign rx_o  = rx_reg;
    assign ry_o  = ry_reg;
    assign wx_o  = wx_reg;
    assign wy_o  = wy_reg;
    assign sb_o  = sb_reg;

endmodule

// ----- rtl/tcm_div_chain.sv -----
// Row of division cells giving an unsigned quotient and remainder per lane.
module tcm_div_chain #(
    parameter int NW  = 64,
    parameter int DW  = 13,
    parameter int SBW = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_i,
    input  logic [DW-1:0]  dx,
    input  logic [DW-1:0]  dy,
    input  logic [NW-1:0]  wx_i,
    input  logic [NW-1:0]  wy_i,
    input  logic [SBW-1:0] sb_i,
    output logic           vld_o,
    output logic [NW-1:0]  qx_o,
    output logic [NW-1:0]  qy_o,
    output logic [DW-1:0]  rx_o,
    output logic [DW-1:0]  ry_o,
    output logic [SBW-1:0] sb_o
);

    logic           vld [NW+1];
    logic [DW-1:0]  rx  [NW+1];
    logic [DW-1:0]  ry  [NW+1];
    logic [NW-1:0]  wx  [NW+1];
    logic [NW-1:0]  wy  [NW+1];
    logic [SBW-1:0] sb  [NW+1];

    assign vld[0] = vld_i;
    assign rx[0]  = '0;
    assign ry[0]  = '0;
    assign wx[0]  = wx_i;
    assign wy[0]  = wy_i;
    assign sb[0]  = sb_i;

    for (genvar i = 0; i < NW; i++) begin : g_cell
        tcm_div_cell #(.NW(NW), .DW(DW), .SBW(SBW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_i(vld[i]), .dx(dx), .dy(dy),
            .rx_i(rx[i]), .ry_i(ry[i]), .wx_i(wx[i]), .wy_i(wy[i]), .sb_i(sb[i]),
            .vld_o(vld[i+1]), .rx_o(rx[i+1]), .ry_o(ry[i+1]),
            .wx_o(wx[i+1]), .wy_o(wy[i+1]), .sb_o(sb[i+1])
        );
    end

    assign vld_o = vld[NW];
    assign qx_o  = wx[NW];
    assign qy_o  = wy[NW];
    assign rx_o  = rx[NW];
    assign ry_o  = ry[NW];
    assign sb_o  = sb[NW];

endmodule

// ----- rtl/tiled_coordinate_mapper.sv -----
// Tiled coordinate mapper: block coordinates to chunk, local and large-chunk coordinates.
//
// Input word: s_block_x/s_block_y on s_valid/s_ready. Result word: chunk, local,
// local index, large-chunk coordinates and config_error on m_valid/m_ready.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 chunk width, 1 chunk height,
// 2 large width, 3 large height) and cfg_data; cfg_ready is always high. Write
// registers only while no word is in flight.
// The pipeline holds one cell per quotient bit in the chunk divider row, a
// local-offset register and a local-index register, then one cell per quotient
// bit in the large-chunk divider row.
// Throughput is one word per cycle unless the receiver stalls; all stages move together.
// When the receiver stalls with a result waiting, every stage holds and s_ready
// drops; a bubble at the output lets the pipeline move on regardless.
// Negative coordinates are bit-inverted before division and the quotient is
// inverted back, which gives floor division with no overflow.
// Reset clears all valid bits and loads the register defaults (16, 16, 32, 32).
// config_error is high when chunk width times chunk height exceeds 1048576;
// local_index then reads zero.
module tiled_coordinate_mapper #(
    parameter int COORD_WIDTH   = tcm_pkg::COORD_WIDTH_DEF,
    parameter int MAX_CHUNK_DIM = tcm_pkg::MAX_CHUNK_DEF,
    parameter int MAX_LARGE_DIM = tcm_pkg::MAX_LARGE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tcm_pkg::FIELD_W-1:0]      s_block_x,
    input  logic [tcm_pkg::FIELD_W-1:0]      s_block_y,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tcm_pkg::FIELD_W-1:0]      m_chunk_x,
    output logic [tcm_pkg::FIELD_W-1:0]      m_chunk_y,
    output logic [tcm_pkg::LOCAL_W-1:0]      m_local_x,
    output logic [tcm_pkg::LOCAL_W-1:0]      m_local_y,
    output logic [tcm_pkg::INDEX_W-1:0]      m_local_index,
    output logic [tcm_pkg::FIELD_W-1:0]      m_large_x,
    output logic [tcm_pkg::FIELD_W-1:0]      m_large_y,
    output logic                             m_config_error,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    `include "assert_macros.svh"

    localparam int W    = COORD_WIDTH;
    localparam int CDW  = $clog2(MAX_CHUNK_DIM + 1);
    localparam int LDW  = $clog2(MAX_LARGE_DIM + 1);
    localparam int PW   = 2 * CDW;
    localparam int SBWB = 2 * W + 2 * CDW + tcm_pkg::INDEX_W + 2;

    logic [tcm_pkg::CHUNK_REG_W-1:0] cw_reg, ch_reg;
    logic [tcm_pkg::LARGE_REG_W-1:0] lw_reg, lh_reg;
    logic [CDW-1:0] cw_eff, ch_eff;
    logic [LDW-1:0] lw_eff, lh_eff;
    logic           cfg_err_reg;
    logic [PW-1:0]  area;
    logic           en;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= tcm_pkg::CHUNK_REG_W'(16);
            ch_reg <= tcm_pkg::CHUNK_REG_W'(16);
            lw_reg <= tcm_pkg::LARGE_REG_W'(32);
            lh_reg <= tcm_pkg::LARGE_REG_W'(32);
        end else if (cfg_valid && cfg_ready) begin
            unique case (tcm_pkg::cfg_index_t'(cfg_index))
                tcm_pkg::CFG_CHUNK_WIDTH:  cw_reg <= cfg_data[tcm_pkg::CHUNK_REG_W-1:0];
                tcm_pkg::CFG_CHUNK_HEIGHT: ch_reg <= cfg_data[tcm_pkg::CHUNK_REG_W-1:0];
                tcm_pkg::CFG_LARGE_WIDTH:  lw_reg <= cfg_data[tcm_pkg::LARGE_REG_W-1:0];
                tcm_pkg::CFG_LARGE_HEIGHT: lh_reg <= cfg_data[tcm_pkg::LARGE_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // zero reads as one, oversize saturates
    assign cw_eff = (cw_reg == '0) ? CDW'(1) :
                    (32'(cw_reg) > MAX_CHUNK_DIM) ? CDW'(MAX_CHUNK_DIM) : CDW'(cw_reg);
    assign ch_eff = (ch_reg == '0) ? CDW'(1) :
                    (32'(ch_reg) > MAX_CHUNK_DIM) ? CDW'(MAX_CHUNK_DIM) : CDW'(ch_reg);
    assign lw_eff = (lw_reg == '0) ? LDW'(1) :
                    (32'(lw_reg) > MAX_LARGE_DIM) ? LDW'(MAX_LARGE_DIM) : LDW'(lw_reg);
    assign lh_eff = (lh_reg == '0) ? LDW'(1) :
                    (32'(lh_reg) > MAX_LARGE_DIM) ? LDW'(MAX_LARGE_DIM) : LDW'(lh_reg);

    assign area = PW'(cw_eff) * PW'(ch_eff);

    always_ff @(posedge aclk) begin
        cfg_err_reg <= (tcm_pkg::AREA_CMP_W'(area) >
                        tcm_pkg::AREA_CMP_W'(tcm_pkg::CHUNK_AREA_LIMIT));
    end

    // whole pipeline advances unless a result is stuck at the output
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // chunk divider row
    logic [W-1:0]   bx, by, wx_in, wy_in;
    logic           a_vld;
    logic [W-1:0]   a_qx, a_qy;
    logic [CDW-1:0] a_rx, a_ry;
    logic [1:0]     a_neg;

    assign bx    = s_block_x[W-1:0];
    assign by    = s_block_y[W-1:0];
    assign wx_in = bx[W-1] ? ~bx : bx;
    assign wy_in = by[W-1] ? ~by : by;

    tcm_div_chain #(.NW(W), .DW(CDW), .SBW(2)) u_chunk_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .vld_i(s_valid), .dx(cw_eff), .dy(ch_eff),
        .wx_i(wx_in), .wy_i(wy_in), .sb_i({bx[W-1], by[W-1]}),
        .vld_o(a_vld), .qx_o(a_qx), .qy_o(a_qy), .rx_o(a_rx), .ry_o(a_ry), .sb_o(a_neg)
    );

    // local offsets
    logic           m1_vld_reg;
    logic [W-1:0]   m1_qx_reg, m1_qy_reg;
    logic [CDW-1:0] m1_lx_reg, m1_ly_reg;
    logic [1:0]     m1_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
        end else if (en) begin
            m1_vld_reg <= a_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_qx_reg  <= a_qx;
            m1_qy_reg  <= a_qy;
            m1_lx_reg  <= a_neg[1] ? (cw_eff - a_rx - CDW'(1)) : a_rx;
            m1_ly_reg  <= a_neg[0] ? (ch_eff - a_ry - CDW'(1)) : a_ry;
            m1_neg_reg <= a_neg;
        end
    end

    // local index
    logic [PW-1:0]                  lsum;
    logic                           m2_vld_reg;
    logic [W-1:0]                   m2_qx_reg, m2_qy_reg;
    logic [CDW-1:0]                 m2_lx_reg, m2_ly_reg;
    logic [tcm_pkg::INDEX_W-1:0]    m2_idx_reg;
    logic [1:0]                     m2_neg_reg;

    assign lsum = PW'(m1_ly_reg) * PW'(cw_eff) + PW'(m1_lx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (en) begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_qx_reg  <= m1_qx_reg;
            m2_qy_reg  <= m1_qy_reg;
            m2_lx_reg  <= m1_lx_reg;
            m2_ly_reg  <= m1_ly_reg;
            m2_idx_reg <= cfg_err_reg ? '0 : tcm_pkg::INDEX_W'(lsum);
            m2_neg_reg <= m1_neg_reg;
        end
    end

    // large-chunk divider row; the chunk quotient enters still in its inverted form
    logic            b_vld;
    logic [W-1:0]    b_qx, b_qy;
    logic [LDW-1:0]  b_rx, b_ry;
    logic [SBWB-1:0] b_sb;
    logic [W-1:0]    o_qx, o_qy, o_cx, o_cy, o_gx, o_gy;
    logic [CDW-1:0]  o_lx, o_ly;
    logic [tcm_pkg::INDEX_W-1:0] o_idx;
    logic [1:0]      o_neg;

    tcm_div_chain #(.NW(W), .DW(LDW), .SBW(SBWB)) u_large_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .vld_i(m2_vld_reg), .dx(lw_eff), .dy(lh_eff),
        .wx_i(m2_qx_reg), .wy_i(m2_qy_reg),
        .sb_i({m2_qx_reg, m2_qy_reg, m2_lx_reg, m2_ly_reg, m2_idx_reg, m2_neg_reg}),
        .vld_o(b_vld), .qx_o(b_qx), .qy_o(b_qy), .rx_o(b_rx), .ry_o(b_ry), .sb_o(b_sb)
    );

    assign {o_qx, o_qy, o_lx, o_ly, o_idx, o_neg} = b_sb;

    // floor remainders of the second division are not used
    logic unused_rem;
    assign unused_rem = ^{b_rx, b_ry};

    assign o_cx = o_neg[1] ? ~o_qx : o_qx;
    assign o_cy = o_neg[0] ? ~o_qy : o_qy;
    assign o_gx = o_neg[1] ? ~b_qx : b_qx;
    assign o_gy = o_neg[0] ? ~b_qy : b_qy;

    assign m_valid        = b_vld;
    assign m_chunk_x      = tcm_pkg::FIELD_W'(signed'(o_cx));
    assign m_chunk_y      = tcm_pkg::FIELD_W'(signed'(o_cy));
    assign m_large_x      = tcm_pkg::FIELD_W'(signed'(o_gx));
    assign m_large_y      = tcm_pkg::FIELD_W'(signed'(o_gy));
    assign m_local_x      = tcm_pkg::LOCAL_W'(o_lx);
    assign m_local_y      = tcm_pkg::LOCAL_W'(o_ly);
    assign m_local_index  = o_idx;
    assign m_config_error = cfg_err_reg | (unused_rem & 1'b0);

    `TCM_ASSERT_IMP(a_local_x_range, m_valid, o_lx < cw_eff)
    `TCM_ASSERT_IMP(a_err_zero_index, m_valid && m_config_error, m_local_index == '0)
    `TCM_ASSERT_NXT(a_reset_clears, !aresetn, !m_valid)

endmodule
